### rtl/mwcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_pkg
// Shared types and constants of the mask window count dilation block.
// ----------------------------------------------------------------------------
package mwcd_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_HEIGHT     = 4096;

  localparam int DIM_W  = 13;
  localparam int KS_W   = 3;
  localparam int TH_W   = 6;
  localparam int CODE_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [KS_W-1:0]  KS_RST     = 3'd3;
  localparam logic [TH_W-1:0]  TH_RST     = 6'd0;

  localparam logic [CODE_W-1:0] CODE_MATCH = 2'd0;
  localparam logic [CODE_W-1:0] CODE_DIFF  = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_t;

  // One pipeline step handed from position control to the window
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              last;
    logic [CODE_W-1:0] code;
    logic [DIM_W-1:0]  in_row;
  } step_t;

  // Window result handed to the threshold stage
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic              last;
    logic [CODE_W-1:0] center;
  } col_res_t;

endpackage

### rtl/mwcd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_in_if
// Mask pixel input channel.
// ----------------------------------------------------------------------------
interface mwcd_in_if import mwcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CODE_W-1:0] pixel_code;

  modport source (output valid, action, pixel_code, input ready);
  modport sink   (input valid, action, pixel_code, output ready);
endinterface

### rtl/mwcd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_out_if
// Cleaned mask pixel output channel.
// ----------------------------------------------------------------------------
interface mwcd_out_if import mwcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_code;
  logic              last_pixel;

  modport source (output valid, out_code, last_pixel, input ready);
  modport sink   (input valid, out_code, last_pixel, output ready);
endinterface

### rtl/mwcd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface mwcd_cfg_if import mwcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mwcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mwcd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mwcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_ctrl
// Configuration registers and input/output raster position tracking.
// ----------------------------------------------------------------------------
module mwcd_ctrl import mwcd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int WID_W = COL_W + 1,
  localparam int NR    = 2 * MAX_RADIUS + 1,
  localparam int RM_W  = $clog2(NR),
  localparam int RAD_W = $clog2(MAX_RADIUS + 1),
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  mwcd_in_if.sink           in_if,
  mwcd_cfg_if.sink          cfg_if,
  input  logic              adv_i,
  output step_t             step_o,
  output logic              wr_o,
  output logic [COL_W-1:0]  col_o,
  output logic [RM_W-1:0]   rmod_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [DIM_W-1:0]  hgt_o,
  output logic [TH_W-1:0]   th_o
);

  logic [DIM_W-1:0] img_w_r, img_w_nxt;
  logic [DIM_W-1:0] img_h_r, img_h_nxt;
  logic [KS_W-1:0]  ks_r, ks_nxt;
  logic [TH_W-1:0]  th_r, th_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [DIM_W-1:0] in_row_r, in_row_nxt;
  logic [RM_W-1:0]  rmod_r, rmod_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [DIM_W-2:0] out_row_r, out_row_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [WID_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [KS_W-1:0]  half_ks;
  logic [RAD_W-1:0] r_eff;
  logic [POS_W-1:0] lag;
  logic             in_frame, take, emit, last, in_eol, out_eol;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(img_w_r);
    end
    if (img_h_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_r;
    end
    half_ks = ks_r >> 1;
    if (32'(half_ks) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = RAD_W'(half_ks);
    end
  end

  assign lag      = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
  assign in_frame = in_row_r < h_eff;
  assign take     = in_if.valid && adv_i && !(in_frame && in_if.action == ACT_FLUSH);
  assign emit     = pos_r >= lag;
  assign in_eol   = WID_W'(in_col_r) == w_eff - WID_W'(1);
  assign out_eol  = WID_W'(out_col_r) == w_eff - WID_W'(1);
  assign last     = emit && out_eol && (DIM_W'(out_row_r) == h_eff - DIM_W'(1));

  always_comb begin
    img_w_nxt   = img_w_r;
    img_h_nxt   = img_h_r;
    ks_nxt      = ks_r;
    th_nxt      = th_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    rmod_nxt    = rmod_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pos_nxt     = pos_r;
    if (cfg_if.valid) begin
      case (reg_idx_t'(cfg_if.index))
        REG_WIDTH:  img_w_nxt = cfg_if.data;
        REG_HEIGHT: img_h_nxt = cfg_if.data;
        REG_KERNEL: ks_nxt    = cfg_if.data[KS_W-1:0];
        REG_THRESH: th_nxt    = cfg_if.data[TH_W-1:0];
        default:    img_w_nxt = img_w_r;
      endcase
    end
    if (cfg_if.valid || (take && last)) begin
      // restart frame position; stored rows stay
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      rmod_nxt    = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pos_nxt     = '0;
    end else if (take) begin
      pos_nxt = pos_r + POS_W'(1);
      if (in_eol) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + DIM_W'(1);
        rmod_nxt   = (rmod_r == RM_W'(NR - 1)) ? '0 : rmod_r + RM_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (out_eol) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + (DIM_W-1)'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= WIDTH_RST;
      img_h_r   <= HEIGHT_RST;
      ks_r      <= KS_RST;
      th_r      <= TH_RST;
      in_col_r  <= '0;
      in_row_r  <= '0;
      rmod_r    <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pos_r     <= '0;
    end else begin
      img_w_r   <= img_w_nxt;
      img_h_r   <= img_h_nxt;
      ks_r      <= ks_nxt;
      th_r      <= th_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      rmod_r    <= rmod_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pos_r     <= pos_nxt;
    end
  end

  assign in_if.ready  = adv_i;
  assign cfg_if.ready = 1'b1;

  assign step_o.valid  = take;
  assign step_o.emit   = emit;
  assign step_o.last   = last;
  assign step_o.code   = in_if.pixel_code;
  assign step_o.in_row = in_row_r;
  assign wr_o          = take && in_frame;
  assign col_o         = in_col_r;
  assign rmod_o        = rmod_r;
  assign rad_o         = r_eff;
  assign hgt_o         = h_eff;
  assign th_o          = th_r;

endmodule

### rtl/mwcd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_window
// Line store bank, column assembly, window shift register and column counts.
// ----------------------------------------------------------------------------
module mwcd_window import mwcd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int NR    = 2 * MAX_RADIUS + 1,
  localparam int RM_W  = $clog2(NR),
  localparam int RAD_W = $clog2(MAX_RADIUS + 1),
  localparam int CW1   = $clog2(NR + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv_i,
  input  step_t                    step_i,
  input  logic                     wr_i,
  input  logic [COL_W-1:0]         col_i,
  input  logic [RM_W-1:0]          rmod_i,
  input  logic [RAD_W-1:0]         rad_i,
  input  logic [DIM_W-1:0]         hgt_i,
  output col_res_t                 res_o,
  output logic [NR-1:0][CW1-1:0]   cnt_o
);

  function automatic logic [RM_W-1:0] ring_sel(input logic [RM_W-1:0] m, input int i);
    if (int'(m) >= i) begin
      return RM_W'(int'(m) - i);
    end
    return RM_W'(int'(m) + NR - i);
  endfunction

  logic              p1_valid_r;
  step_t             p1_step_r;
  logic [RM_W-1:0]   p1_rmod_r;
  logic              p2_valid_r, p2_emit_r, p2_last_r;
  logic [CODE_W-1:0] rdata [NR];
  logic [CODE_W-1:0] vec [NR];
  logic [CODE_W-1:0] win_r [NR][NR];
  logic [DIM_W-1:0]  wrow_r [NR];
  logic [CW1-1:0]    cnt [NR];
  logic [CODE_W-1:0] center;

  for (genvar j = 0; j < NR; j++) begin : g_line
    mwcd_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_i && rmod_i == RM_W'(j)),
      .waddr (col_i),
      .wdata (step_i.code),
      .re    (adv_i),
      .raddr (col_i),
      .rdata (rdata[j])
    );
  end

  // Column of codes under the newest pixel; rows outside the frame read as matches
  always_comb begin
    for (int i = 0; i < NR; i++) begin
      if ((i <= 2 * int'(rad_i)) && (i <= int'(p1_step_r.in_row)) &&
          (int'(p1_step_r.in_row) < int'(hgt_i) + i)) begin
        vec[i] = (i == 0) ? p1_step_r.code : rdata[ring_sel(p1_rmod_r, i)];
      end else begin
        vec[i] = CODE_MATCH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      p1_step_r <= step_i;
      p1_rmod_r <= rmod_i;
      if (p1_valid_r) begin
        win_r[0]  <= vec;
        wrow_r[0] <= p1_step_r.in_row;
        for (int k = 1; k < NR; k++) begin
          win_r[k]  <= win_r[k-1];
          wrow_r[k] <= wrow_r[k-1];
        end
      end
      p2_emit_r <= p1_step_r.emit;
      p2_last_r <= p1_step_r.last;
    end
  end

  // Keep only columns of the center's row group
  always_comb begin
    center = win_r[RM_W'(rad_i)][RM_W'(rad_i)];
    for (int k = 0; k < NR; k++) begin
      cnt[k] = '0;
      if ((k <= 2 * int'(rad_i)) && (wrow_r[k] == wrow_r[RM_W'(rad_i)])) begin
        for (int i = 0; i < NR; i++) begin
          if (win_r[k][i] == CODE_DIFF) begin
            cnt[k] = cnt[k] + CW1'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      res_o.emit   <= p2_emit_r;
      res_o.last   <= p2_last_r;
      res_o.center <= center;
      for (int k = 0; k < NR; k++) begin
        cnt_o[k] <= cnt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      res_o.valid <= 1'b0;
    end else if (adv_i) begin
      p1_valid_r  <= step_i.valid;
      p2_valid_r  <= p1_valid_r;
      res_o.valid <= p2_valid_r;
    end
  end

endmodule

### rtl/mwcd_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcd_decide
// Window sum, threshold test and output register.
// ----------------------------------------------------------------------------
module mwcd_decide import mwcd_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int NR    = 2 * MAX_RADIUS + 1,
  localparam int CW1   = $clog2(NR + 1),
  localparam int CNT_W = $clog2(NR * NR + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  col_res_t               res_i,
  input  logic [NR-1:0][CW1-1:0] cnt_i,
  input  logic [TH_W-1:0]        th_i,
  output logic                   adv_o,
  mwcd_out_if.source             out_if
);

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r, code_nxt;
  logic              out_last_r;
  logic [CNT_W-1:0]  sum;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NR; k++) begin
      sum = sum + CNT_W'(cnt_i[k]);
    end
    code_nxt = res_i.center;
    if (res_i.center == CODE_MATCH && int'(sum) > int'(th_i)) begin
      code_nxt = CODE_DIFF;
    end
  end

  // hold while the result waits for a transfer
  assign adv_o = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_o) begin
      out_valid_r <= res_i.valid && res_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_code_r <= code_nxt;
      out_last_r <= res_i.last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_code   = out_code_r;
  assign out_if.last_pixel = out_last_r;

endmodule

### rtl/mask_window_count_dilate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_window_count_dilate_top
// Window count dilation of a raster stream of two-bit mask pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock while the output
// is not stalled: the path is a four-stage pipeline (position control with
// line store access, column assembly into the window shift register,
// per-column counts, sum and threshold into the output register), and the
// result stream lags the input stream by radius rows plus radius pixels.
// The window reads the last 2*MAX_RADIUS+1 rows from one line store RAM per
// ring row, all read at one column per clock while the output is not stalled.
// Line stores start undefined and need no clearing. After the frame's last
// pixel send flush items (action 1) to drain the tail; a register write
// restarts the frame position.
// ----------------------------------------------------------------------------
module mask_window_count_dilate_top import mwcd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mwcd_in_if.sink    in_if,
  mwcd_out_if.source out_if,
  mwcd_cfg_if.sink   cfg_if
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int NR    = 2 * MAX_RADIUS + 1;
  localparam int RM_W  = $clog2(NR);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int CW1   = $clog2(NR + 1);

  logic                   adv;
  step_t                  step;
  logic                   wr;
  logic [COL_W-1:0]       col;
  logic [RM_W-1:0]        rmod;
  logic [RAD_W-1:0]       rad;
  logic [DIM_W-1:0]       hgt;
  logic [TH_W-1:0]        th;
  col_res_t               res;
  logic [NR-1:0][CW1-1:0] cnt;

  mwcd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .adv_i  (adv),
    .step_o (step),
    .wr_o   (wr),
    .col_o  (col),
    .rmod_o (rmod),
    .rad_o  (rad),
    .hgt_o  (hgt),
    .th_o   (th)
  );

  mwcd_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .step_i (step),
    .wr_i   (wr),
    .col_i  (col),
    .rmod_i (rmod),
    .rad_i  (rad),
    .hgt_i  (hgt),
    .res_o  (res),
    .cnt_o  (cnt)
  );

  mwcd_decide #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_decide (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_i  (res),
    .cnt_i  (cnt),
    .th_i   (th),
    .adv_o  (adv),
    .out_if (out_if)
  );

endmodule

### tb/mask_window_count_dilate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_window_count_dilate_checker
// Watches the pixel, result and register channels of the dilation block,
// predicts every cleaned pixel from its own line store copy and compares
// each result transfer with the oldest expected pixel.
// ----------------------------------------------------------------------------
module mask_window_count_dilate_checker import mwcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mwcd_in_if   in_ch,
  mwcd_out_if  out_ch,
  mwcd_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  localparam int RING = 2 * MAX_RADIUS_DEF + 1;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
  } mask_px_t;

  logic [CODE_W-1:0] ring_rows [RING][MAX_WIDTH_DEF];
  int unsigned in_col, in_row, out_col, out_row;
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [KS_W-1:0]  kernel_reg;
  logic [TH_W-1:0]  thresh_reg;
  mask_px_t expected_px [$];

  function automatic int unsigned frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned radius();
    int unsigned r;
    r = kernel_reg / 2;
    return (r > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : r;
  endfunction

  function automatic int unsigned diff_count(int unsigned row, int unsigned col);
    int y0, y1, x0, x1;
    int unsigned cnt;
    y0 = int'(row) - int'(radius());
    y1 = int'(row) + int'(radius());
    x0 = int'(col) - int'(radius());
    x1 = int'(col) + int'(radius());
    cnt = 0;
    if (y0 < 0) y0 = 0;
    if (y1 > int'(frame_h()) - 1) y1 = int'(frame_h()) - 1;
    if (x0 < 0) x0 = 0;
    if (x1 > int'(frame_w()) - 1) x1 = int'(frame_w()) - 1;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++)
        if (ring_rows[y % RING][x] == CODE_DIFF) cnt++;
    return cnt;
  endfunction

  function automatic void restart_position();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  task automatic predict_pixel(input logic act, input logic [CODE_W-1:0] code);
    int unsigned w, h, r, n, idx;
    mask_px_t px;
    w = frame_w();
    h = frame_h();
    r = radius();
    if (in_row < h) begin
      if (act == ACT_FLUSH) return;
      ring_rows[in_row % RING][in_col] = code;
    end
    n = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < r * w + r) return;
    px.code = ring_rows[out_row % RING][out_col];
    if (px.code == CODE_MATCH && diff_count(out_row, out_col) > thresh_reg)
      px.code = CODE_DIFF;
    idx = out_row * w + out_col;
    px.last = (idx + 1 >= w * h);
    expected_px.push_back(px);
    if (px.last) begin
      restart_position();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < RING; i++)
      for (int j = 0; j < MAX_WIDTH_DEF; j++)
        ring_rows[i][j] = CODE_MATCH;
  end

  always @(posedge clk) begin
    mask_px_t exp_px;
    if (!rst_n) begin
      restart_position();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      kernel_reg = KS_RST;
      thresh_reg = TH_RST;
      expected_px.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_WIDTH:  width_reg = cfg_ch.data;
          REG_HEIGHT: height_reg = cfg_ch.data;
          REG_KERNEL: kernel_reg = cfg_ch.data[KS_W-1:0];
          REG_THRESH: thresh_reg = cfg_ch.data[TH_W-1:0];
          default: ;
        endcase
        restart_position();
      end
      if (in_ch.valid && in_ch.ready)
        predict_pixel(in_ch.action, in_ch.pixel_code);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result code %0d last %0b", $time,
                   out_ch.out_code, out_ch.last_pixel);
          fail_count++;
        end else begin
          exp_px = expected_px.pop_front();
          if (out_ch.out_code !== exp_px.code || out_ch.last_pixel !== exp_px.last) begin
            $display("%0t: mismatch expected code %0d last %0b, actual code %0d last %0b",
                     $time, exp_px.code, exp_px.last, out_ch.out_code, out_ch.last_pixel);
            fail_count++;
          end
        end
      end
    end
    pending = expected_px.size();
  end

endmodule

### tb/mask_window_count_dilate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_window_count_dilate_top_tb
// Streams mask frames of many sizes, kernels and thresholds through the
// dilation block under varying idle and stall patterns, with flush tails,
// stray flushes and late pixels; the checker compares every result.
// ----------------------------------------------------------------------------
module mask_window_count_dilate_top_tb;
  import mwcd_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending;
  int   idle_pct, stall_pct;
  int   sent;

  mwcd_in_if  in_if ();
  mwcd_out_if out_if ();
  mwcd_cfg_if cfg_if ();

  mask_window_count_dilate_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  mask_window_count_dilate_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_ch     (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic act, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.pixel_code <= code;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold until every result has left, then let the pipeline settle
  task automatic drain_wait();
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [KS_W-1:0] k, input logic [TH_W-1:0] t);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_KERNEL, k);
    write_reg(REG_THRESH, t);
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    int p;
    p = $urandom_range(99);
    if (p < 45) return CODE_MATCH;
    if (p < 85) return CODE_DIFF;
    if (p < 95) return 2'd2;
    return 2'd3;
  endfunction

  // one frame of real pixels, with stray flushes when noisy, then the drain tail
  task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned k,
                           input bit noisy, input bit hold_once);
    int unsigned ew, eh, r, total, tail;
    int unsigned hold_at;
    ew = (w == 0) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    eh = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    r = (k / 2 > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : k / 2;
    total = ew * eh;
    tail = (r * ew + r < total) ? r * ew + r : total;
    hold_at = $urandom_range(total - 1);
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(ACT_FLUSH, $urandom_range(3));
      if (hold_once && i == hold_at) begin
        stop_sending();
        while (pending != 0) @(negedge clk);
      end
      send_item(ACT_PIXEL, rand_code());
    end
    for (int unsigned i = 0; i < tail; i++) begin
      if (noisy && $urandom_range(7) == 0) send_item(ACT_PIXEL, rand_code());
      else send_item(ACT_FLUSH, $urandom_range(3));
    end
    if (noisy)
      repeat ($urandom_range(2)) send_item(ACT_FLUSH, $urandom_range(3));
  endtask

  task automatic random_phase(input int idle, input int stall, input int budget);
    int unsigned w, h, k, t;
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(10, 1);
      h = $urandom_range(6, 1);
      k = $urandom_range(7);
      t = ($urandom_range(7) == 0) ? 63 : $urandom_range(12);
      stop_sending();
      drain_wait();
      set_frame(w, h, k, t);
      run_frame(w, h, k, 1'b1, $urandom_range(3) == 0);
    end
    stop_sending();
  endtask

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_PIXEL;
    in_if.pixel_code = CODE_MATCH;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_WIDTH;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // a few pixels under the reset frame, then restart by register writes
    repeat (4) send_item(ACT_PIXEL, rand_code());
    stop_sending();
    drain_wait();
    set_frame(4, 3, 3, 0);
    send_item(ACT_FLUSH, 2'd0);
    send_item(ACT_PIXEL, CODE_DIFF);
    send_item(ACT_PIXEL, CODE_MATCH);
    send_item(ACT_PIXEL, 2'd2);
    send_item(ACT_PIXEL, 2'd3);
    send_item(ACT_FLUSH, 2'd3);
    for (int i = 0; i < 8; i++) send_item(ACT_PIXEL, (i % 3 == 0) ? CODE_DIFF : CODE_MATCH);
    send_item(ACT_PIXEL, CODE_DIFF);
    repeat (4) send_item(ACT_FLUSH, 2'd1);
    send_item(ACT_FLUSH, 2'd0);
    stop_sending();
    drain_wait();
    set_frame(0, 0, 7, 63);
    run_frame(0, 0, 7, 1'b0, 1'b0);
    stop_sending();
    drain_wait();
    set_frame(13'h1FFF, 1, 0, 0);
    run_frame(13'h1FFF, 1, 0, 1'b0, 1'b0);
    stop_sending();
    drain_wait();
    set_frame(1, 13'h1FFF, 2, 1);
    run_frame(1, 13'h1FFF, 2, 1'b0, 1'b0);
    stop_sending();
    drain_wait();
    set_frame(9, 7, 6, 2);
    run_frame(9, 7, 6, 1'b0, 1'b1);
    stop_sending();

    random_phase(0, 0, 125);
    random_phase(83, 0, 125);
    random_phase(0, 83, 125);
    random_phase(31, 31, 125);

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
